### sv/fast12_corner_segment_test_defines.svh
// -----------------------------------------------------------------------------
// fast12_corner_segment_test_defines.svh
// Assertion macros used by the corner segment test checker.
// -----------------------------------------------------------------------------
`ifndef FAST12_CORNER_SEGMENT_TEST_DEFINES_SVH
`define FAST12_CORNER_SEGMENT_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define F12CST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("f12cst check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define F12CST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("f12cst check failed");

`endif

### sv/f12cst_pkg.sv
// -----------------------------------------------------------------------------
// f12cst_pkg
// Constants and types of the FAST-12 corner segment test.
// -----------------------------------------------------------------------------
`default_nettype none

package f12cst_pkg;

  localparam int RING_SIZE   = 16;
  localparam int ARC_LENGTH  = 12;
  localparam int COUNT_WIDTH = 20;

  localparam int PIX_W       = 8;
  localparam int THR_W       = 8;
  localparam int LIM_W       = PIX_W + 2;
  localparam int HALF_W      = PIX_W * RING_SIZE / 2;
  localparam int OUT_COUNT_W = 20;

  localparam int S_TDATA_W   = PIX_W + 2 * HALF_W + RING_SIZE;
  localparam int M_TDATA_RAW = 1 + OUT_COUNT_W;
  localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

  localparam logic [THR_W-1:0]       THR_RESET = THR_W'(20);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic bright;
    logic dark;
  } lane_flags_t;

endpackage

`default_nettype wire

### sv/f12cst_lane.sv
// -----------------------------------------------------------------------------
// f12cst_lane
// Classifies one circle pixel as at least threshold brighter and/or darker than the center.
// -----------------------------------------------------------------------------
`default_nettype none

module f12cst_lane (
  input  var logic signed [f12cst_pkg::PIX_W-1:0] pixel_i,
  input  var logic signed [f12cst_pkg::PIX_W-1:0] center_i,
  input  var logic        [f12cst_pkg::THR_W-1:0] threshold_i,
  input  var logic                                valid_i,
  output f12cst_pkg::lane_flags_t                 flags_o
);

  logic signed [f12cst_pkg::LIM_W-1:0] pix_w;
  logic signed [f12cst_pkg::LIM_W-1:0] ctr_w;
  logic signed [f12cst_pkg::LIM_W-1:0] thr_w;
  logic signed [f12cst_pkg::LIM_W-1:0] bright_lim;
  logic signed [f12cst_pkg::LIM_W-1:0] dark_lim;

  assign pix_w      = f12cst_pkg::LIM_W'(pixel_i);
  assign ctr_w      = f12cst_pkg::LIM_W'(center_i);
  assign thr_w      = $signed({2'b00, threshold_i});
  assign bright_lim = ctr_w + thr_w;
  assign dark_lim   = ctr_w - thr_w;

  always_comb begin
    flags_o.bright = valid_i && (pix_w >= bright_lim);
    flags_o.dark   = valid_i && (pix_w <= dark_lim);
  end

endmodule

`default_nettype wire

### sv/f12cst_merge.sv
// -----------------------------------------------------------------------------
// f12cst_merge
// Combines the lane flags: searches every wrapped arc for a full run.
// -----------------------------------------------------------------------------
`default_nettype none

module f12cst_merge (
  input  f12cst_pkg::lane_flags_t [f12cst_pkg::RING_SIZE-1:0] flags_i,
  output logic                                                corner_o
);

  logic [f12cst_pkg::RING_SIZE-1:0]   bright;
  logic [f12cst_pkg::RING_SIZE-1:0]   dark;
  logic [2*f12cst_pkg::RING_SIZE-1:0] bright_dbl;
  logic [2*f12cst_pkg::RING_SIZE-1:0] dark_dbl;
  logic [f12cst_pkg::RING_SIZE-1:0]   bright_hit;
  logic [f12cst_pkg::RING_SIZE-1:0]   dark_hit;

  always_comb begin
    for (int k = 0; k < f12cst_pkg::RING_SIZE; k++) begin
      bright[k] = flags_i[k].bright;
      dark[k]   = flags_i[k].dark;
    end
    bright_dbl = {bright, bright};
    dark_dbl   = {dark, dark};
    for (int s = 0; s < f12cst_pkg::RING_SIZE; s++) begin
      bright_hit[s] = &bright_dbl[s +: f12cst_pkg::ARC_LENGTH];
      dark_hit[s]   = &dark_dbl[s +: f12cst_pkg::ARC_LENGTH];
    end
    corner_o = (|bright_hit) || (|dark_hit);
  end

endmodule

`default_nettype wire

### sv/fast12_corner_segment_test.sv
// -----------------------------------------------------------------------------
// fast12_corner_segment_test
// FAST-12 segment test over 16 circle pixels with a running corner count.
// -----------------------------------------------------------------------------
// channel  | dir | tdata (low bit up)                         | tuser
// s_axis   | in  | center, ring low, ring high, ring valid    | image_start
// m_axis   | out | is_corner, corners_so_far, 3 pad bits      | -
// cfg      | in  | threshold (cfg_we_i / cfg_wdata_i)         | -
//
// One word per cycle sustained while the output is not stalled.
// Stage one registers the 16 lane compares, the output stage registers the
// arc search and the saturating count.
// Reset clears the pipe, the count and sets threshold to 20.
// Input stalls only when both stages hold words and the output is stalled.
// -----------------------------------------------------------------------------
`default_nettype none

module fast12_corner_segment_test (
  input  var logic                               clk_i,
  input  var logic                               rst_ni,
  input  var logic                               s_axis_tvalid,
  output logic                                   s_axis_tready,
  // center_pixel[7:0], ring_pixels_low[71:8], ring_pixels_high[135:72],
  // ring_valid[151:136]
  input  var logic [f12cst_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // image_start[0]
  input  var logic [0:0]                         s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  var logic                               m_axis_tready,
  // is_corner[0], corners_so_far[20:1], zero pad[23:21]
  output logic [f12cst_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  input  var logic                               cfg_we_i,
  input  var logic [f12cst_pkg::THR_W-1:0]       cfg_wdata_i
);

  localparam int RING_LO = f12cst_pkg::PIX_W;
  localparam int VAL_LO  = f12cst_pkg::PIX_W + 2 * f12cst_pkg::HALF_W;
  localparam int RING_W  = 2 * f12cst_pkg::HALF_W;

  logic [f12cst_pkg::THR_W-1:0]       thr_q;
  logic signed [f12cst_pkg::PIX_W-1:0] center;
  logic [RING_W-1:0]                  ring;
  logic [f12cst_pkg::RING_SIZE-1:0]   ring_valid;

  f12cst_pkg::lane_flags_t [f12cst_pkg::RING_SIZE-1:0] lane_flags;
  f12cst_pkg::lane_flags_t [f12cst_pkg::RING_SIZE-1:0] flags_q;

  logic                               s1_valid_q;
  logic                               s1_start_q;
  logic                               out_valid_q;
  logic                               out_valid_d;
  logic                               out_corner_q;
  logic                               out_load;
  logic                               in_accept;
  logic                               corner;
  logic [f12cst_pkg::COUNT_WIDTH-1:0] count_q;
  logic [f12cst_pkg::COUNT_WIDTH-1:0] count_base;
  logic [f12cst_pkg::COUNT_WIDTH-1:0] count_d;

  assign center     = $signed(s_axis_tdata[f12cst_pkg::PIX_W-1:0]);
  assign ring       = s_axis_tdata[RING_LO +: RING_W];
  assign ring_valid = s_axis_tdata[VAL_LO +: f12cst_pkg::RING_SIZE];

  for (genvar k = 0; k < f12cst_pkg::RING_SIZE; k++) begin : g_lane
    f12cst_lane u_lane (
      .pixel_i     ($signed(ring[k*f12cst_pkg::PIX_W +: f12cst_pkg::PIX_W])),
      .center_i    (center),
      .threshold_i (thr_q),
      .valid_i     (ring_valid[k]),
      .flags_o     (lane_flags[k])
    );
  end

  f12cst_merge u_merge (
    .flags_i  (flags_q),
    .corner_o (corner)
  );

  assign out_load      = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || out_load;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    count_base = s1_start_q ? '0 : count_q;
    count_d    = count_base;
    if (corner && (count_base != f12cst_pkg::COUNT_MAX)) begin
      count_d = count_base + f12cst_pkg::COUNT_WIDTH'(1);
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= f12cst_pkg::THR_RESET;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      out_corner_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
      if (out_load) begin
        count_q      <= count_d;
        out_corner_q <= corner;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      flags_q    <= lane_flags;
      s1_start_q <= s_axis_tuser[0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = f12cst_pkg::M_TDATA_W'(
    {f12cst_pkg::OUT_COUNT_W'(count_q), out_corner_q});

endmodule

`default_nettype wire

### sv/f12cst_checker.sv
// -----------------------------------------------------------------------------
// f12cst_checker
// Port-level checks of the corner segment test, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "fast12_corner_segment_test_defines.svh"

module f12cst_checker (
  input var logic                             clk_i,
  input var logic                             rst_ni,
  input var logic                             s_axis_tready,
  input var logic                             m_axis_tvalid,
  input var logic                             m_axis_tready,
  input var logic [f12cst_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic                               out_corner;
  logic [f12cst_pkg::OUT_COUNT_W-1:0] out_count;

  assign out_corner = m_axis_tdata[0];
  assign out_count  = m_axis_tdata[f12cst_pkg::OUT_COUNT_W:1];

  `F12CST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  `F12CST_ASSERT_NOW(a_corner_counted, m_axis_tvalid && out_corner, out_count != '0)

  `F12CST_ASSERT_NOW(a_stall_only_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind fast12_corner_segment_test f12cst_checker u_f12cst_checker (.*);

`default_nettype wire
